### design/cbpm_pkg.sv
package cbpm_pkg;

  typedef enum logic [2:0] {
    OP_READ    = 3'd0,
    OP_UNPIN   = 3'd1,
    OP_ALLOC   = 3'd2,
    OP_DISPOSE = 3'd3,
    OP_FLUSH   = 3'd4
  } op_t;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_PRESENT = 3'd1;
  localparam logic [2:0] ST_NOT_PINNED  = 3'd2;
  localparam logic [2:0] ST_EXCEEDED    = 3'd3;
  localparam logic [2:0] ST_PINNED      = 3'd4;

  localparam int unsigned FRAME_FIELD_CAP = 16;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  file_id;
    logic [31:0] page_num;
    logic        mark_dirty;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  frame;
    logic        hit;
    logic        write_back;
    logic [7:0]  victim_file;
    logic [31:0] victim_page;
    logic        last;
  } rsp_t;

  // Per-frame descriptor as held in the descriptor memory.
  typedef struct packed {
    logic        valid;
    logic [7:0]  pin;
    logic        ref_bit;
    logic        dirty;
    logic [7:0]  file_id;
    logic [31:0] page;
  } desc_t;

endpackage

### design/cbpm_req_if.sv
interface cbpm_req_if;
  import cbpm_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### design/cbpm_rsp_if.sv
interface cbpm_rsp_if;
  import cbpm_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### design/clock_buffer_pool_manager_core.sv
// Buffer pool manager with clock replacement. Frame descriptors live in one
// synchronous memory with a registered read; the block handles one request at a
// time. Each frame visited takes a read issue, then a decide and write-back
// step. A lookup scans up to the N frames in use, a read miss or alloc adds a
// clock sweep, and a flush scans the N frames once, stopping early at a pinned
// page of its file. A result waits in an output register; the next request is
// taken once that register is free. The memory is cleared after reset by a
// pass over all NUM_FRAMES entries, during which no request is taken.
module clock_buffer_pool_manager_core
  import cbpm_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  cbpm_req_if.sink   in_req,
  cbpm_rsp_if.source out_rsp,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata
);

  localparam int unsigned AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned LIM = (NUM_FRAMES < FRAME_FIELD_CAP) ? NUM_FRAMES
                                                                 : FRAME_FIELD_CAP;
  localparam int unsigned GW = $clog2(2 * LIM + 3);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LK_RD, S_LK_CHK, S_SW_RD, S_SW_CHK,
    S_FL_RD, S_FL_CHK, S_OUT
  } state_t;

  desc_t mem [NUM_FRAMES];
  desc_t rd_q;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  desc_t       wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  state_t        state_r;
  logic [4:0]    fiu_r;
  req_t          req_r;
  rsp_t          rsp_r;
  logic          rsp_v_r;
  logic [AW-1:0] idx_r;
  logic [AW-1:0] hand_r;
  logic [AW-1:0] start_r;
  logic [CW-1:0] pinned_r;
  logic [GW-1:0] guard_r;
  logic          cleared_r;

  // Active frame count, clipped to [1, LIM].
  logic [CW-1:0] n_act;
  always_comb begin
    if (fiu_r == 5'd0) n_act = CW'(1);
    else if (32'(fiu_r) > LIM) n_act = CW'(LIM);
    else n_act = CW'(fiu_r);
  end

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] h, input logic [CW-1:0] n);
    logic [CW-1:0] c;
    c = CW'(h) + CW'(1);
    return (c >= n) ? '0 : c[AW-1:0];
  endfunction

  logic key_match;
  assign key_match = rd_q.valid && rd_q.file_id == req_r.file_id
                     && rd_q.page == req_r.page_num;

  assign in_req.ready = (state_r == S_IDLE) && !rsp_v_r;
  assign out_rsp.valid = rsp_v_r;
  assign out_rsp.payload = rsp_r;

  function automatic rsp_t mk(input logic [2:0] st, input logic [3:0] fr,
                              input logic h, input logic l);
    rsp_t r;
    r = '0;
    r.status = st;
    r.frame = fr;
    r.hit = h;
    r.last = l;
    return r;
  endfunction

  // An ok result that hands a page back to the host for write-back.
  function automatic rsp_t mk_wb(input logic [3:0] fr, input logic l,
                                 input logic [7:0] vf, input logic [31:0] vp);
    rsp_t r;
    r = mk(ST_OK, fr, 1'b0, l);
    r.write_back = 1'b1;
    r.victim_file = vf;
    r.victim_page = vp;
    return r;
  endfunction

  desc_t loaded;
  always_comb begin
    loaded = '0;
    loaded.valid = 1'b1;
    loaded.pin = 8'd1;
    loaded.ref_bit = 1'b1;
    loaded.file_id = req_r.file_id;
    loaded.page = req_r.page_num;
  end

  always_comb begin
    we = 1'b0;
    waddr = idx_r;
    wdata = rd_q;
    raddr = idx_r;
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        wdata = '0;
      end
      S_SW_RD: raddr = hand_r;
      S_SW_CHK: begin
        waddr = hand_r;
        raddr = hand_r;
      end
      default: ;
    endcase
    case (state_r)
      S_LK_CHK: begin
        if (key_match) begin
          case (req_r.op)
            OP_READ: begin
              we = 1'b1;
              wdata.ref_bit = 1'b1;
              if (rd_q.pin != 8'hFF) wdata.pin = rd_q.pin + 8'd1;
            end
            OP_UNPIN: begin
              if (rd_q.pin != 8'd0) begin
                we = 1'b1;
                wdata.pin = rd_q.pin - 8'd1;
                if (req_r.mark_dirty) wdata.dirty = 1'b1;
              end
            end
            OP_DISPOSE: begin
              we = 1'b1;
              wdata = '0;
            end
            default: ;
          endcase
        end
      end
      S_SW_CHK: begin
        if (!rd_q.valid) begin
          we = 1'b1;
          wdata = loaded;
        end else if (!(pinned_r == n_act && hand_r == start_r)) begin
          if (rd_q.ref_bit) begin
            we = 1'b1;
            wdata.ref_bit = 1'b0;
          end else if (rd_q.pin == 8'd0) begin
            we = 1'b1;
            wdata = loaded;
          end
        end
      end
      S_FL_CHK: begin
        if (rd_q.valid && rd_q.file_id == req_r.file_id && rd_q.pin == 8'd0) begin
          we = 1'b1;
          wdata = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      fiu_r <= 5'd16;
      rsp_v_r <= 1'b0;
      idx_r <= '0;
      hand_r <= AW'(LIM - 1);
      cleared_r <= 1'b0;
    end else begin
      if (cfg_we) fiu_r <= cfg_wdata;
      if (rsp_v_r && out_rsp.ready) rsp_v_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          if (32'(idx_r) == NUM_FRAMES - 1) begin
            idx_r <= '0;
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_req.valid && in_req.ready) begin
            req_r <= in_req.payload;
            idx_r <= '0;
            case (in_req.payload.op)
              OP_READ, OP_UNPIN, OP_DISPOSE: state_r <= S_LK_RD;
              OP_ALLOC: begin
                hand_r <= adv(hand_r, n_act);
                start_r <= adv(hand_r, n_act);
                pinned_r <= '0;
                guard_r <= '0;
                state_r <= S_SW_RD;
              end
              OP_FLUSH: state_r <= S_FL_RD;
              default: ;
            endcase
          end
        end
        S_LK_RD: state_r <= S_LK_CHK;
        S_LK_CHK: begin
          if (key_match) begin
            case (req_r.op)
              OP_UNPIN: rsp_r <= mk((rd_q.pin == 8'd0) ? ST_NOT_PINNED : ST_OK,
                                    4'(idx_r), 1'b0, 1'b1);
              default: rsp_r <= mk(ST_OK, 4'(idx_r), req_r.op == OP_READ, 1'b1);
            endcase
            state_r <= S_OUT;
          end else if (CW'(idx_r) + CW'(1) >= n_act) begin
            if (req_r.op == OP_READ) begin
              hand_r <= adv(hand_r, n_act);
              start_r <= adv(hand_r, n_act);
              pinned_r <= '0;
              guard_r <= '0;
              state_r <= S_SW_RD;
            end else begin
              rsp_r <= mk(ST_NOT_PRESENT, 4'd0, 1'b0, 1'b1);
              state_r <= S_OUT;
            end
          end else begin
            idx_r <= idx_r + AW'(1);
            state_r <= S_LK_RD;
          end
        end
        S_SW_RD: state_r <= S_SW_CHK;
        S_SW_CHK: begin
          guard_r <= guard_r + GW'(1);
          if (!rd_q.valid) begin
            rsp_r <= mk(ST_OK, 4'(hand_r), 1'b0, 1'b1);
            state_r <= S_OUT;
          end else if ((pinned_r == n_act && hand_r == start_r)
                       || 32'(guard_r) >= 2 * 32'(n_act) + 1) begin
            rsp_r <= mk(ST_EXCEEDED, 4'd0, 1'b0, 1'b1);
            state_r <= S_OUT;
          end else begin
            if (rd_q.pin != 8'd0) pinned_r <= pinned_r + CW'(1);
            if (rd_q.ref_bit || rd_q.pin != 8'd0) begin
              hand_r <= adv(hand_r, n_act);
              state_r <= S_SW_RD;
            end else begin
              rsp_r <= rd_q.dirty ? mk_wb(4'(hand_r), 1'b1, rd_q.file_id, rd_q.page)
                                  : mk(ST_OK, 4'(hand_r), 1'b0, 1'b1);
              state_r <= S_OUT;
            end
          end
        end
        S_FL_RD: begin
          if (!rsp_v_r) state_r <= S_FL_CHK;
        end
        S_FL_CHK: begin
          if (rd_q.valid && rd_q.file_id == req_r.file_id && rd_q.pin != 8'd0) begin
            rsp_r <= mk(ST_PINNED, 4'(idx_r), 1'b0, 1'b1);
            state_r <= S_OUT;
          end else begin
            if (rd_q.valid && rd_q.file_id == req_r.file_id && rd_q.dirty) begin
              rsp_r <= mk_wb(4'(idx_r), 1'b0, rd_q.file_id, rd_q.page);
              rsp_v_r <= 1'b1;
            end
            if (CW'(idx_r) + CW'(1) >= n_act) begin
              cleared_r <= 1'b1;
              state_r <= S_OUT;
            end else begin
              idx_r <= idx_r + AW'(1);
              state_r <= S_FL_RD;
            end
          end
        end
        S_OUT: begin
          // A flush close waits for its last write-back transfer to drain.
          if (cleared_r) begin
            if (!rsp_v_r) begin
              rsp_r <= mk(ST_OK, 4'd0, 1'b0, 1'b1);
              rsp_v_r <= 1'b1;
              cleared_r <= 1'b0;
              state_r <= S_IDLE;
            end
          end else begin
            rsp_v_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
